// ----- hdl/wism_pkg.sv -----
`default_nettype none

package wism_pkg;

  // Template entry layout, low bits first.
  localparam int ENTRY_W        = 60;
  localparam int NUM_ENTRY_REGS = 4;
  localparam int NUM_FIELDS     = 7;
  localparam int MASK_LSB       = 53;
  localparam int START_W        = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int LEN_W          = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd4;

  localparam logic [LEN_W-1:0] LEN_RESET = 3'd1;

  typedef struct packed {
    logic [6:0]         opcode;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic [4:0]         rd;
    logic signed [20:0] imm;
  } instr_t;

  // Per-cell control, shared by every cell in the row.
  typedef struct packed {
    logic adv;    // an instruction transfers this cycle
    logic clear;  // it opens a new program
  } cell_ctl_t;

  // Masked compare of one instruction against one template entry.
  function automatic logic entry_match(input logic [ENTRY_W-1:0] ent, input instr_t x);
    logic [NUM_FIELDS-1:0] eq;
    logic [NUM_FIELDS-1:0] msk;
    eq[0] = (ent[6:0]   == x.opcode);
    eq[1] = (ent[9:7]   == x.funct3);
    eq[2] = (ent[16:10] == x.funct7);
    eq[3] = (ent[21:17] == x.rs1);
    eq[4] = (ent[26:22] == x.rs2);
    eq[5] = (ent[31:27] == x.rd);
    eq[6] = (ent[52:32] == x.imm);
    msk   = ent[MASK_LSB +: NUM_FIELDS];
    return &(eq | ~msk);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/wism_if.sv -----
`default_nettype none

interface wism_in_if;
  logic               valid;
  logic               ready;
  logic               program_start;
  logic [6:0]         instr_opcode;
  logic [2:0]         instr_funct3;
  logic [6:0]         instr_funct7;
  logic [4:0]         instr_rs1;
  logic [4:0]         instr_rs2;
  logic [4:0]         instr_rd;
  logic signed [20:0] instr_imm;

  modport source (
    output valid, program_start, instr_opcode, instr_funct3, instr_funct7,
           instr_rs1, instr_rs2, instr_rd, instr_imm,
    input  ready
  );
  modport sink (
    input  valid, program_start, instr_opcode, instr_funct3, instr_funct7,
           instr_rs1, instr_rs2, instr_rd, instr_imm,
    output ready
  );
endinterface

interface wism_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [19:0] match_start;

  modport source (
    output valid, match_found, match_start,
    input  ready
  );
  modport sink (
    input  valid, match_found, match_start,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/wism_cell.sv -----
`default_nettype none

module wism_cell import wism_pkg::*; #(
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cell_ctl_t          ctl_i,
  input  wire logic               prev_i,   // left neighbor's stored bit
  input  wire instr_t             instr_i,
  input  wire logic [ENTRY_W-1:0] entry_i,
  output logic                    hit_o,    // prefix 0..k ends at this instruction
  output logic                    p_o       // stored bit handed to the right neighbor
);

  logic m;

  assign m = entry_match(entry_i, instr_i);

  generate
    if (FIRST) begin : g_first
      assign hit_o = m;
    end else begin : g_link
      // a new program drops whatever the neighbor carried
      assign hit_o = m & prev_i & ~ctl_i.clear;
    end

    if (LAST) begin : g_tail
      assign p_o = 1'b0;
    end else begin : g_hold
      logic p_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          p_q <= 1'b0;
        end else if (ctl_i.adv) begin
          p_q <= hit_o;
        end
      end
      assign p_o = p_q;
    end
  endgenerate

endmodule

`default_nettype wire

// ----- hdl/wildcard_instruction_sequence_matcher_top.sv -----
`default_nettype none

// Wildcard instruction sequence matcher.
// Input channel in_i carries one decoded instruction per transfer; program_start
// marks the first instruction of a program and clears the partial matches and
// the instruction index. Output channel out_o carries one result per input
// transfer: match_found and match_start, the index where the occurrence began
// (zero when nothing matched).
// The user must load the template (four entries plus length) via the write port
// cfg_we_i/cfg_idx_i/cfg_data_i while no instruction is in flight (not enforced).
// Latency: a result appears on out_o the cycle after its input transfer.
// Throughput: one instruction per cycle while the receiver keeps up. Each cycle
// every cell does its masked compare, and all but the first combine it with the
// left neighbor's stored prefix bit; that single compare-and-shift sets the rate.
// When the receiver stalls the result holds in the output register, and the
// input keeps accepting as long as that register is freed in the same cycle.
// Reset: empty output register, no partial matches, index zero, all template
// fields wildcard, pattern length one.

module wildcard_instruction_sequence_matcher_top import wism_pkg::*; #(
  parameter int MAX_PATTERN = 4,
  parameter int INDEX_BITS  = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ENTRY_W-1:0]   cfg_data_i,
  wism_in_if.sink                   in_i,
  wism_out_if.source                out_o
);

  localparam int PW   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int LM_W = (MAX_PATTERN > 8) ? 4 : 3;

  // Template registers.
  logic [ENTRY_W-1:0] entry_q [NUM_ENTRY_REGS];
  logic [LEN_W-1:0]   len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRY_REGS; i++) entry_q[i] <= '0;
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRY_0: entry_q[0] <= cfg_data_i;
        CFG_ENTRY_1: entry_q[1] <= cfg_data_i;
        CFG_ENTRY_2: entry_q[2] <= cfg_data_i;
        CFG_ENTRY_3: entry_q[3] <= cfg_data_i;
        CFG_LENGTH:  len_q      <= cfg_data_i[LEN_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Handshake: the output register frees itself when its result transfers.
  logic out_valid_q;
  logic in_acc;
  cell_ctl_t ctl;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;
  assign ctl.adv    = in_acc;
  assign ctl.clear  = in_i.program_start;

  instr_t instr;
  assign instr.opcode = in_i.instr_opcode;
  assign instr.funct3 = in_i.instr_funct3;
  assign instr.funct7 = in_i.instr_funct7;
  assign instr.rs1    = in_i.instr_rs1;
  assign instr.rs2    = in_i.instr_rs2;
  assign instr.rd     = in_i.instr_rd;
  assign instr.imm    = in_i.instr_imm;

  // Row of cells; cell k owns template entry k and, except the last, prefix bit k.
  logic [MAX_PATTERN-1:0] hit;
  logic [PW-1:0]          part;

  generate
    if (MAX_PATTERN == 1) begin : g_nopart
      assign part = '0;
    end
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [ENTRY_W-1:0] ent;
      logic               prev;
      logic               p;
      if (k < NUM_ENTRY_REGS) begin : g_ent
        assign ent = entry_q[k];
      end else begin : g_wild
        assign ent = '0;  // entries past the registers match anything
      end
      if (k == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_chain
        assign prev = part[k-1];
      end
      if (k < MAX_PATTERN - 1) begin : g_out
        assign part[k] = p;
      end

      wism_cell #(
        .FIRST (k == 0),
        .LAST  (k == MAX_PATTERN - 1)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl),
        .prev_i  (prev),
        .instr_i (instr),
        .entry_i (ent),
        .hit_o   (hit[k]),
        .p_o     (p)
      );
    end
  endgenerate

  // Effective length minus one: zero acts as one, clamp at the row size.
  logic [LM_W-1:0] len_m1;
  always_comb begin
    int lm;
    lm = int'(len_q);
    if (lm < 1) lm = 1;
    if (lm > MAX_PATTERN) lm = MAX_PATTERN;
    len_m1 = LM_W'(lm - 1);
  end

  logic found;
  always_comb begin
    found = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (int'(len_m1) == k) found = hit[k];
    end
  end

  // Instruction index, restarted by program_start.
  logic [INDEX_BITS-1:0] idx_q;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [INDEX_BITS-1:0] start_idx;

  assign cur_idx   = in_i.program_start ? '0 : idx_q;
  assign start_idx = cur_idx - INDEX_BITS'(len_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (in_acc) begin
      idx_q <= cur_idx + INDEX_BITS'(1);
    end
  end

  // Output register.
  logic               found_q;
  logic [START_W-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found_q <= found;
      start_q <= found ? START_W'(start_idx) : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match_found = found_q;
  assign out_o.match_start = start_q;

`ifndef SYNTHESIS
  a_restart_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.program_start) |=> (idx_q == INDEX_BITS'(1)))
    else $error("index not restarted by program_start");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted instruction produced no result");

  a_start_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (start_q == '0))
    else $error("match_start nonzero without a match");
`endif

endmodule

`default_nettype wire
